// ===== src/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the line command responder.
// ----------------------------------------------------------------------------
package lcr_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_PONG  = 2'd1;
    localparam logic [1:0] KIND_NET   = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam logic [0:0] CFG_IP   = 1'b0;
    localparam logic [0:0] CFG_PORT = 1'b1;

    // Datapath command from the controller.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_STORE = 4'd1,   // write rx byte, bump fill count
        OP_TRIM  = 4'd2,   // step length down past trailing CR/LF
        OP_SCAN  = 4'd3,   // check one stored byte against both commands
        OP_EMIT  = 4'd4,   // load output register from current byte source
        OP_CLEAR = 4'd5,   // fill count back to zero
        OP_DIGIT = 4'd6    // one decimal digit-extraction step
    } lcr_op_t;

    typedef enum logic [2:0] {
        SRC_STORE = 3'd0,  // store byte at index
        SRC_PONG  = 3'd1,
        SRC_HEAD  = 3'd2,
        SRC_DIGIT = 3'd3,
        SRC_CHAR  = 3'd4   // fixed character from the controller
    } lcr_src_t;

    typedef struct packed {
        lcr_op_t     op;
        lcr_src_t    src;
        logic [5:0]  idx;
        logic [7:0]  chr;
        logic [1:0]  kind;
        logic        last;
        logic        load_val;  // start a decimal conversion
        logic [2:0]  val_sel;   // 0..3 octets, 4 port
    } lcr_cmd_t;

    typedef struct packed {
        logic        scan_fetched;
        logic [5:0]  fill;
        logic [5:0]  len;
        logic        trail_crlf;  // byte at len-1 is CR or LF
        logic        ping_ok;
        logic        net_ok;
        logic [3:0]  dig_cnt;     // digits captured
        logic        dig_done;
    } lcr_stat_t;

    function automatic logic [7:0] pong_char(input logic [5:0] i);
        case (i[2:0])
            3'd0: pong_char = 8'h50;
            3'd1: pong_char = 8'h4F;
            3'd2: pong_char = 8'h4E;
            3'd3: pong_char = 8'h47;
            3'd4: pong_char = CH_CR;
            default: pong_char = CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] ping_char(input logic [1:0] i);
        case (i)
            2'd0: ping_char = 8'h50;
            2'd1: ping_char = 8'h49;
            2'd2: ping_char = 8'h4E;
            default: ping_char = 8'h47;
        endcase
    endfunction

    // "OK NET TEST IP=" then " PORT=" at offset 15
    function automatic logic [7:0] head_char(input logic [5:0] i);
        case (i[4:0])
            5'd0:  head_char = 8'h4F;
            5'd1:  head_char = 8'h4B;
            5'd2:  head_char = CH_SP;
            5'd3:  head_char = 8'h4E;
            5'd4:  head_char = 8'h45;
            5'd5:  head_char = 8'h54;
            5'd6:  head_char = CH_SP;
            5'd7:  head_char = 8'h54;
            5'd8:  head_char = 8'h45;
            5'd9:  head_char = 8'h53;
            5'd10: head_char = 8'h54;
            5'd11: head_char = CH_SP;
            5'd12: head_char = 8'h49;
            5'd13: head_char = 8'h50;
            5'd14: head_char = 8'h3D;
            5'd15: head_char = CH_SP;
            5'd16: head_char = 8'h50;
            5'd17: head_char = 8'h4F;
            5'd18: head_char = 8'h52;
            5'd19: head_char = 8'h54;
            default: head_char = 8'h3D;
        endcase
    endfunction

    function automatic logic [7:0] net_char(input logic [2:0] i);
        case (i)
            3'd0: net_char = 8'h4E;
            3'd1: net_char = 8'h45;
            3'd2: net_char = 8'h54;
            3'd3: net_char = CH_SP;
            3'd4: net_char = 8'h54;
            3'd5: net_char = 8'h45;
            3'd6: net_char = 8'h53;
            default: net_char = 8'h54;
        endcase
    endfunction

endpackage

// ===== src/lcr_datapath.sv =====
// ----------------------------------------------------------------------------
// lcr_datapath
// Line store, fill count, trim/compare flags, decimal converter, output reg.
// ----------------------------------------------------------------------------
module lcr_datapath #(
    parameter int LINE_BYTES = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcr_pkg::lcr_cmd_t cmd,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       ip_address,
    input  logic [15:0]       server_port,
    output lcr_pkg::lcr_stat_t stat,
    output logic [7:0]        out_byte,
    output logic [1:0]        out_kind,
    output logic              out_last
);
    import lcr_pkg::*;

    logic [7:0] mem [LINE_BYTES];
    logic [7:0] rd_reg;
    logic       fetched_reg;
    logic [5:0] fill_reg, len_reg;
    logic       ping_reg, net_reg;
    logic [15:0] val_reg;
    logic [7:0]  dig_reg [5];
    logic [3:0]  dcnt_reg;
    logic        ddone_reg;
    logic [7:0]  ob_reg;
    logic [1:0]  ok_reg;
    logic        ol_reg;

    logic [15:0] val_sel;
    logic [15:0] quot;
    logic [3:0]  rem;
    logic [7:0]  src_byte;
    logic        blank;
    logic [31:0] prod;

    always_comb begin
        case (cmd.val_sel)
            3'd0: val_sel = {8'd0, ip_address[31:24]};
            3'd1: val_sel = {8'd0, ip_address[23:16]};
            3'd2: val_sel = {8'd0, ip_address[15:8]};
            3'd3: val_sel = {8'd0, ip_address[7:0]};
            default: val_sel = server_port;
        endcase
    end

    // divide by ten: multiply by reciprocal, then one correction
    always_comb begin
        logic [15:0] q;
        logic [19:0] r;
        prod = 32'(val_reg) * 32'd52429;
        q = {3'd0, prod[31:19]};
        r = 20'(val_reg) - 20'(q) * 20'd10;
        if (r >= 20'd10) begin
            quot = q + 16'd1;
            rem  = 4'(r - 20'd10);
        end else begin
            quot = q;
            rem  = r[3:0];
        end
    end

    always_comb begin
        case (cmd.src)
            SRC_STORE: src_byte = rd_reg;
            SRC_PONG:  src_byte = pong_char(cmd.idx);
            SRC_HEAD:  src_byte = head_char(cmd.idx);
            SRC_DIGIT: src_byte = dig_reg[cmd.idx[2:0]];
            default:   src_byte = cmd.chr;
        endcase
    end

    assign blank = rd_reg == CH_CR || rd_reg == CH_LF || rd_reg == CH_SP || rd_reg == CH_TAB;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_STORE) mem[fill_reg] <= rx_byte;
        rd_reg <= mem[cmd.idx];
        if (cmd.op == OP_DIGIT) dig_reg[dcnt_reg[2:0]] <= CH_0 + {4'd0, rem};
        if (cmd.op == OP_EMIT) begin
            ob_reg <= src_byte;
            ok_reg <= cmd.kind;
            ol_reg <= cmd.last;
        end
        if (cmd.load_val) val_reg <= val_sel;
        else if (cmd.op == OP_DIGIT) val_reg <= quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            len_reg     <= '0;
            ping_reg    <= 1'b0;
            net_reg     <= 1'b0;
            fetched_reg <= 1'b0;
            dcnt_reg    <= '0;
            ddone_reg   <= 1'b0;
        end else begin
            fetched_reg <= cmd.op == OP_TRIM || cmd.op == OP_SCAN;
            if (cmd.load_val) begin
                dcnt_reg  <= '0;
                ddone_reg <= 1'b0;
            end else if (cmd.op == OP_DIGIT) begin
                dcnt_reg  <= dcnt_reg + 4'd1;
                ddone_reg <= quot == 16'd0;
            end
            case (cmd.op)
                OP_STORE: begin
                    fill_reg <= fill_reg + 6'd1;
                    len_reg  <= fill_reg + 6'd1;
                    ping_reg <= 1'b1;
                    net_reg  <= 1'b1;
                end
                OP_CLEAR: begin
                    fill_reg <= '0;
                    len_reg  <= '0;
                    ping_reg <= 1'b1;
                    net_reg  <= 1'b1;
                end
                OP_TRIM: if (fetched_reg && (rd_reg == CH_CR || rd_reg == CH_LF))
                    len_reg <= len_reg - 6'd1;
                OP_SCAN: if (fetched_reg) begin
                    // cmd.idx was the previous fetch address plus one
                    if (cmd.idx - 6'd1 < 6'd4) begin
                        if (rd_reg != ping_char(2'(cmd.idx - 6'd1))) ping_reg <= 1'b0;
                    end else if (!blank) ping_reg <= 1'b0;
                    if (cmd.idx - 6'd1 < 6'd8) begin
                        if (rd_reg != net_char(3'(cmd.idx - 6'd1))) net_reg <= 1'b0;
                    end else if (!blank) net_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        stat.scan_fetched = fetched_reg;
        stat.fill         = fill_reg;
        stat.len          = len_reg;
        stat.trail_crlf   = rd_reg == CH_CR || rd_reg == CH_LF;
        stat.ping_ok      = ping_reg && len_reg >= 6'd4;
        stat.net_ok       = net_reg && len_reg >= 6'd8;
        stat.dig_cnt      = dcnt_reg;
        stat.dig_done     = ddone_reg;
    end

    assign out_byte = ob_reg;
    assign out_kind = ok_reg;
    assign out_last = ol_reg;

endmodule

// ===== src/lcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcr_ctrl
// Sequencer: stores bytes, trims and scans a finished line, walks the reply.
// ----------------------------------------------------------------------------
module lcr_ctrl #(
    parameter int LINE_BYTES = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    input  lcr_pkg::lcr_stat_t stat,
    output lcr_pkg::lcr_cmd_t  cmd
);
    import lcr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRIM  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_SHOW  = 9'b001000000,
        S_CONV  = 9'b010000000,
        S_FLUSH = 9'b100000000
    } state_t;

    // reply phases
    typedef enum logic [3:0] {
        PH_ECHO, PH_CRLF, PH_PONG, PH_HEAD, PH_NUM, PH_DOT, PH_PORT,
        PH_FLUSH
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      ph_reg, ph_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  vsel_reg, vsel_next;
    logic [1:0]  kind_reg, kind_next;
    logic        endr_reg, endr_next;  // current output byte is the last one

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_SHOW;

    // next state and datapath command; on a taken byte, work out the next byte position
    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        vsel_next  = vsel_reg;
        kind_next  = kind_reg;
        endr_next  = endr_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.src    = SRC_CHAR;
        cmd.kind   = kind_reg;
        cmd.idx    = idx_reg;
        cmd.val_sel = vsel_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                idx_next = '0;
                if (s_rx_byte != CH_LF) begin
                    cmd.op = OP_STORE;
                    if (stat.fill == 6'(LINE_BYTES - 1)) begin
                        kind_next  = KIND_FLUSH;
                        ph_next    = PH_FLUSH;
                        state_next = S_FETCH;
                    end
                end else begin
                    cmd.idx    = stat.len - 6'd1;
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                cmd.idx = stat.len - 6'd1;
                if (stat.len == 6'd0 || (stat.scan_fetched && !stat.trail_crlf)) begin
                    cmd.idx    = '0;
                    state_next = S_SCAN;
                end else if (stat.scan_fetched) begin
                    cmd.op  = OP_TRIM;
                    cmd.idx = stat.len - 6'd2;
                end else begin
                    cmd.op = OP_TRIM;
                end
            end
            S_SCAN: begin
                if (stat.scan_fetched) begin
                    cmd.op   = OP_SCAN;
                    cmd.idx  = idx_reg + 6'd1;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg + 6'd1 >= stat.len) state_next = S_PICK;
                end else if (stat.len == 6'd0) begin
                    state_next = S_PICK;
                end else begin
                    cmd.op  = OP_SCAN;
                    cmd.idx = idx_reg;
                end
            end
            S_PICK: begin
                idx_next   = '0;
                state_next = S_FETCH;
                if (stat.ping_ok) begin
                    kind_next = KIND_PONG;
                    ph_next   = PH_PONG;
                end else if (stat.net_ok) begin
                    kind_next = KIND_NET;
                    ph_next   = PH_HEAD;
                end else begin
                    kind_next = KIND_ECHO;
                    ph_next   = stat.len == 6'd0 ? PH_CRLF : PH_ECHO;
                end
            end
            S_FETCH: begin
                cmd.idx    = idx_reg;
                state_next = S_LOAD;
                if (ph_reg == PH_NUM && idx_reg == 6'd0) begin
                    cmd.load_val = 1'b1;
                    state_next   = S_CONV;
                end
            end
            S_CONV: begin
                cmd.op = OP_DIGIT;
                if (stat.dig_cnt != 4'd0 && stat.dig_done) begin
                    cmd.op     = OP_NONE;
                    idx_next   = 6'(stat.dig_cnt);
                    state_next = S_FETCH;
                end
            end
            S_LOAD: begin
                cmd.op  = OP_EMIT;
                cmd.idx = idx_reg;
                endr_next = 1'b0;
                case (ph_reg) inside
                    PH_ECHO, PH_FLUSH: cmd.src = SRC_STORE;
                    PH_PONG: begin
                        cmd.src = SRC_PONG;
                        endr_next = idx_reg == 6'd5;
                    end
                    PH_HEAD, PH_PORT: cmd.src = SRC_HEAD;
                    PH_NUM: begin
                        cmd.src = SRC_DIGIT;
                        cmd.idx = idx_reg - 6'd1;
                    end
                    PH_DOT: cmd.chr = CH_DOT;
                    default: begin
                        cmd.chr   = idx_reg == 6'd0 ? CH_CR : CH_LF;
                        endr_next = idx_reg == 6'd1;
                    end
                endcase
                if (ph_reg == PH_FLUSH) endr_next = idx_reg == 6'(LINE_BYTES - 1);
                cmd.last   = endr_next;
                state_next = S_SHOW;
            end
            S_SHOW: if (m_ready) begin
                state_next = S_FETCH;
                idx_next   = idx_reg + 6'd1;
                if (endr_reg) begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_IDLE;
                end else begin
                    case (ph_reg)
                        PH_ECHO: if (idx_reg + 6'd1 == stat.len) begin
                            ph_next = PH_CRLF; idx_next = '0;
                        end
                        PH_HEAD: if (idx_reg == 6'd14) begin
                            ph_next = PH_NUM; idx_next = '0; vsel_next = 3'd0;
                        end
                        PH_NUM: begin
                            idx_next = idx_reg - 6'd1;
                            if (idx_reg == 6'd1) begin
                                idx_next = '0;
                                if (vsel_reg == 3'd4) ph_next = PH_CRLF;
                                else if (vsel_reg == 3'd3) begin
                                    ph_next = PH_PORT; idx_next = 6'd15;
                                end else ph_next = PH_DOT;
                            end
                        end
                        PH_DOT: begin
                            ph_next = PH_NUM; idx_next = '0; vsel_next = vsel_reg + 3'd1;
                        end
                        PH_PORT: if (idx_reg == 6'd20) begin
                            ph_next = PH_NUM; idx_next = '0; vsel_next = 3'd4;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_ECHO;
            idx_reg   <= '0;
            vsel_reg  <= '0;
            kind_reg  <= KIND_ECHO;
            endr_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
            vsel_reg  <= vsel_next;
            kind_reg  <= kind_next;
            endr_reg  <= endr_next;
        end
    end

endmodule

// ===== src/line_command_responder_unit.sv =====
// ----------------------------------------------------------------------------
// line_command_responder_unit
// Gathers received text into a line and answers each line with a reply run.
// ----------------------------------------------------------------------------
// Input: s_valid/s_ready transfer one s_rx_byte. A byte other than LF is
// stored. LF ends the line: trailing CR/LF are trimmed (a fetch, then one
// byte a cycle, then a final check), the line is checked against PING and
// NET TEST (a fetch, then one byte a cycle), then the reply goes out on
// m_valid/m_ready, one m_tx_byte per transfer with m_reply_kind, and
// m_last_byte on the final byte. Each reply byte passes the fetch, load
// and show states, read from the store or the constant tables; each
// decimal number is first converted one digit per divide-by-ten step.
// A full store is sent back as kind 3 and cleared.
// s_ready is low from line end until the last reply byte is taken; a
// stalled receiver simply holds the current byte. Reset (aresetn low,
// synchronous) empties the line and loads the register defaults
// 192.168.77.2 and port 5000. Config writes (cfg_we, cfg_index, cfg_data)
// take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module line_command_responder_unit #(
    parameter int LINE_BYTES = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic [1:0]  m_reply_kind,
    output logic        m_last_byte,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lcr_pkg::*;

    lcr_cmd_t    cmd;
    lcr_stat_t   stat;
    logic [31:0] ip_reg;
    logic [15:0] port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg   <= 32'hC0A84D02;
            port_reg <= 16'd5000;
        end else if (cfg_we) begin
            if (cfg_index == CFG_IP) ip_reg <= cfg_data;
            else port_reg <= cfg_data[15:0];
        end
    end

    lcr_ctrl #(.LINE_BYTES(LINE_BYTES)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_rx_byte,
        .m_valid, .m_ready, .stat, .cmd
    );

    lcr_datapath #(.LINE_BYTES(LINE_BYTES)) u_dp (
        .aclk, .aresetn, .cmd, .rx_byte(s_rx_byte),
        .ip_address(ip_reg), .server_port(port_reg), .stat,
        .out_byte(m_tx_byte), .out_kind(m_reply_kind), .out_last(m_last_byte)
    );

endmodule

// ===== tb/line_command_responder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_command_responder_unit_tb
// Streams text bytes into the responder and checks every reply byte.
// A reply predictor mirrors the line store and the two registers. It queues
// the reply bytes that each accepted byte produces, and each reply transfer
// is checked against the oldest queued byte. Both sides stall at random.
// ----------------------------------------------------------------------------
module line_command_responder_unit_tb;
    import lcr_pkg::*;

    localparam int LINE_BYTES = 48;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RAND_BYTES = 250;

    typedef struct {
        logic [7:0] tx_byte;
        logic [1:0] kind;
        logic       last;
    } reply_byte_t;

    class reply_scoreboard;
        logic [7:0]  line_buf [LINE_BYTES];
        int          fill;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
        reply_byte_t pending [$];
        int          errors;
        int          checked;

        function new();
            fill = 0;
            ip_addr = 32'hC0A84D02;
            port_num = 16'd5000;
            errors = 0;
            checked = 0;
        endfunction

        function void push(logic [7:0] b, logic [1:0] kind);
            reply_byte_t r;
            r.tx_byte = b;
            r.kind = kind;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void push_str(string s, logic [1:0] kind);
            for (int i = 0; i < s.len(); i++) push(s[i], kind);
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB;
        endfunction

        function bit cmd_match(string cmd, int len);
            if (len < cmd.len()) return 0;
            for (int i = 0; i < cmd.len(); i++)
                if (line_buf[i] != cmd[i]) return 0;
            for (int i = cmd.len(); i < len; i++)
                if (!is_blank(line_buf[i])) return 0;
            return 1;
        endfunction

        function void note_rx(logic [7:0] b);
            int len;
            if (b != CH_LF) begin
                line_buf[fill] = b;
                fill++;
                if (fill < LINE_BYTES) return;
                for (int i = 0; i < LINE_BYTES; i++) push(line_buf[i], KIND_FLUSH);
                pending[$].last = 1'b1;
                fill = 0;
                return;
            end
            len = fill;
            while (len != 0 && (line_buf[len-1] == CH_CR || line_buf[len-1] == CH_LF))
                len--;
            if (cmd_match("PING", len)) begin
                push_str("PONG", KIND_PONG);
                push(CH_CR, KIND_PONG);
                push(CH_LF, KIND_PONG);
            end else if (cmd_match("NET TEST", len)) begin
                push_str($sformatf("OK NET TEST IP=%0d.%0d.%0d.%0d PORT=%0d",
                    ip_addr[31:24], ip_addr[23:16], ip_addr[15:8], ip_addr[7:0],
                    port_num), KIND_NET);
                push(CH_CR, KIND_NET);
                push(CH_LF, KIND_NET);
            end else begin
                for (int i = 0; i < len; i++) push(line_buf[i], KIND_ECHO);
                push(CH_CR, KIND_ECHO);
                push(CH_LF, KIND_ECHO);
            end
            pending[$].last = 1'b1;
            fill = 0;
        endfunction

        function void check(logic [7:0] tx, logic [1:0] kind, logic last);
            reply_byte_t r;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected reply byte %h", tx);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (tx !== r.tx_byte) begin
                $error("tx_byte: expected %h, got %h", r.tx_byte, tx);
                errors++;
            end
            if (kind !== r.kind) begin
                $error("reply_kind: expected %0d, got %0d", r.kind, kind);
                errors++;
            end
            if (last !== r.last) begin
                $error("last_byte: expected %0d, got %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tx_byte;
    logic [1:0]  m_reply_kind;
    logic        m_last_byte;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_IP;
    logic [31:0] cfg_data = 32'h0;

    logic [31:0] ip_set [4] = '{32'hC0A84D02, 32'h00000000, 32'hFFFFFFFF, 32'h0A000101};
    logic [15:0] port_set [4] = '{16'd5000, 16'd0, 16'd65535, 16'd1};

    reply_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    int  rx_gap = 0;
    int  long_hold = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;

    line_command_responder_unit #(.LINE_BYTES(LINE_BYTES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_tx_byte(m_tx_byte),
        .m_reply_kind(m_reply_kind), .m_last_byte(m_last_byte),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check each transfer, then draw the next stall
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check(m_tx_byte, m_reply_kind, m_last_byte);
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
        end
    end

    always @(negedge aclk) begin
        if (long_hold > 0) begin
            m_ready <= 1'b0;
            long_hold--;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_rx(b);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_blanks(int n);
        logic [7:0] pick [3] = '{CH_SP, CH_TAB, CH_CR};
        for (int i = 0; i < n; i++) send_byte(pick[$urandom_range(0, 2)]);
    endtask

    // one random line; mostly commands and text, some noise and overruns
    task automatic send_random_line();
        int sel;
        int n;
        logic [7:0] b;
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
        case (sel) inside
            0, 1: begin
                send_str("PING");
                send_blanks($urandom_range(0, 3));
                send_byte(CH_LF);
            end
            2, 3: begin
                send_str("NET TEST");
                send_blanks($urandom_range(0, 3));
                send_byte(CH_LF);
            end
            4: begin
                // near misses: truncated or extended commands
                if ($urandom_range(0, 1)) send_str("PIN");
                else send_str("NET TES");
                if ($urandom_range(0, 1)) send_byte(8'h41 + 8'($urandom_range(0, 25)));
                send_blanks($urandom_range(0, 2));
                send_byte(CH_LF);
            end
            5, 6: begin
                n = $urandom_range(0, 20);
                for (int i = 0; i < n; i++) send_byte(8'h20 + 8'($urandom_range(0, 94)));
                send_byte(CH_LF);
            end
            7: begin
                // often long enough to overrun the store
                n = $urandom_range(40, 60);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_LF) b = 8'h00;
                    send_byte(b);
                end
                send_byte(CH_LF);
            end
            default: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 5) == 0) b = CH_LF;
                    send_byte(b);
                end
            end
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one write strobe, then an idle gap so back-to-back writes stay apart
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IP) sb.ip_addr = val;
        else sb.port_num = val[15:0];
        @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: commands, blanks after commands, empty line, extreme bytes
        send_str("PING");
        send_byte(CH_LF);
        send_str("NET TEST");
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_str("PING");
        send_byte(CH_TAB);
        send_byte(CH_SP);
        send_byte(CH_CR);
        send_byte(CH_LF);
        drain();

        for (int p = 0; p < 4; p++) begin
            if (p != 0) begin
                write_reg(CFG_IP, ip_set[p] ^ (p == 3 ? $urandom() : 32'h0));
                write_reg(CFG_PORT, {16'h0, port_set[p]});
            end
            send_str("NET TEST");
            send_byte(CH_LF);
            if (p == 1) begin
                // receiver blocked while a full store and more lines queue up
                long_hold = 400;
                for (int i = 0; i < LINE_BYTES; i++)
                    send_byte(8'($urandom_range(0, 9)) + 8'h30);
                send_str("PING");
                send_byte(CH_LF);
            end
            while (sent < 25 + (p + 1) * RAND_BYTES / 4) send_random_line();
            send_byte(CH_LF);
            drain();
        end

        $display("Sent %0d bytes over four register settings, checked %0d reply bytes.",
            sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/lcr_pkg.sv
src/lcr_datapath.sv
src/lcr_ctrl.sv
src/line_command_responder_unit.sv
tb/line_command_responder_unit_tb.sv
